@@ hdl/gcag_pkg.sv @@
package gcag_pkg;

  // Signed coordinate/axis width: 19 bits signed, enough for sides up to 65536.
  localparam int unsigned CW = 19;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    crd_t       x;
    crd_t       y;
    crd_t       ax;
    crd_t       ay;
    crd_t       bx;
    crd_t       by;
    logic [1:0] ph;
  } frame_t;

  // Request passed from the front queue to the walker.
  typedef struct packed {
    logic              restart;
    logic [12:0]       wd;
    logic [12:0]       ht;
  } req_t;

  typedef struct packed {
    logic [11:0] pix_x;
    logic [11:0] pix_y;
    logic        final_pixel;
    logic        walk_done;
  } res_t;

  function automatic crd_t sgn(input crd_t v);
    crd_t r;
    r = '0;
    if (v > 0) r = crd_t'(1);
    else if (v < 0) r = -crd_t'(1);
    return r;
  endfunction

  function automatic crd_t mag(input crd_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Truncation toward zero halving.
  function automatic crd_t half(input crd_t v);
    crd_t r;
    r = v >>> 1;
    if (v < 0 && v[0]) r = r + crd_t'(1);
    return r;
  endfunction

endpackage

@@ hdl/gcag_front.sv @@
// Request queue: latches restart with the configuration it applies to.
module gcag_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              restart_i,
  input  logic [12:0]       wd_i,
  input  logic [12:0]       ht_i,
  output logic              rvalid_o,
  input  logic              rtake_i,
  output gcag_pkg::req_t    req_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gcag_pkg::req_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          wr, rd;

  assign full_o   = (cnt_q == (AW+1)'(DEPTH));
  assign rvalid_o = (cnt_q != '0);
  assign wr       = push_i && !full_o;
  assign rd       = rtake_i && rvalid_o;
  assign req_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= '{restart: restart_i, wd: wd_i, ht: ht_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
      if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

@@ hdl/gcag_walk.sv @@
// Walker: frame stack plus leaf segment; takes a request only when idle.
module gcag_walk #(
  parameter int unsigned MAX_SIDE    = 4096,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rvalid_i,
  output logic           rtake_o,
  input  gcag_pkg::req_t req_i,
  output logic           empty_o,
  input  logic           pop_i,
  output gcag_pkg::res_t res_o
);
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = gcag_pkg::CW;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_STEP} state_e;

  gcag_pkg::frame_t stk_q [STACK_DEPTH];
  gcag_pkg::frame_t top_q;
  state_e           st_q;
  logic [LW-1:0]    lvl_q;
  gcag_pkg::crd_t   lx_q, ly_q, lsx_q, lsy_q;
  logic [CW-1:0]    lrem_q;
  logic             fin_q;
  logic             ovalid_q;
  gcag_pkg::res_t   res_q;

  // Child frame pushed in the cycle after the parent's phase update.
  logic             cp_q;
  gcag_pkg::frame_t child_q;

  assign empty_o = !ovalid_q;
  assign res_o   = res_q;
  wire out_free  = !ovalid_q || pop_i;
  assign rtake_o = (st_q == S_IDLE) && rvalid_i && out_free;

  // Frame decode of the current top.
  gcag_pkg::crd_t w, h, dax, day, dbx, dby, ax2, ay2, bx2, by2, w2, h2;
  logic           leaf, two;
  always_comb begin
    w   = gcag_pkg::mag(top_q.ax + top_q.ay);
    h   = gcag_pkg::mag(top_q.bx + top_q.by);
    dax = gcag_pkg::sgn(top_q.ax);
    day = gcag_pkg::sgn(top_q.ay);
    dbx = gcag_pkg::sgn(top_q.bx);
    dby = gcag_pkg::sgn(top_q.by);
    ax2 = gcag_pkg::half(top_q.ax);
    ay2 = gcag_pkg::half(top_q.ay);
    bx2 = gcag_pkg::half(top_q.bx);
    by2 = gcag_pkg::half(top_q.by);
    w2  = gcag_pkg::mag(ax2 + ay2);
    h2  = gcag_pkg::mag(bx2 + by2);
    leaf = (h <= 1) || (w <= 1);
    two  = ((w <<< 1) > (h + (h <<< 1)));
    if (two) begin
      if (w2[0] && w > 2) begin
        ax2 = ax2 + dax;
        ay2 = ay2 + day;
      end
    end else if (h2[0] && h > 2) begin
      bx2 = bx2 + dbx;
      by2 = by2 + dby;
    end
  end

  function automatic gcag_pkg::frame_t mk(input gcag_pkg::crd_t x, y, ax, ay, bx, by);
    return '{x: x, y: y, ax: ax, ay: ay, bx: bx, by: by, ph: 2'd0};
  endfunction

  wire [SW-1:0] tix = SW'(lvl_q - LW'(1));
  wire [SW-1:0] pix = SW'(lvl_q);
  wire          ovf = (lvl_q >= LW'(STACK_DEPTH));

  logic [12:0] wd_s, ht_s;
  always_comb begin
    wd_s = (32'(req_i.wd) > MAX_SIDE) ? 13'(MAX_SIDE) : req_i.wd;
    ht_s = (32'(req_i.ht) > MAX_SIDE) ? 13'(MAX_SIDE) : req_i.ht;
  end

  // Result register load this cycle.
  logic emit;
  always_comb begin
    emit = 1'b0;
    if (st_q == S_IDLE) begin
      emit = rtake_o && (req_i.restart ? (wd_s == '0 || ht_s == '0) : fin_q);
    end else if (st_q == S_STEP) begin
      emit = (lrem_q != '0) || (lvl_q == '0) || (cp_q && ovf);
    end
  end

  // Stack memory: one write port, registered read of the top.
  logic             we;
  logic [SW-1:0]    wa;
  gcag_pkg::frame_t wdat;
  always_ff @(posedge clk_i) begin
    if (we) stk_q[wa] <= wdat;
  end

  always_comb begin
    we   = 1'b0;
    wa   = tix;
    wdat = top_q;
    if (st_q == S_STEP && lrem_q == '0 && lvl_q != '0) begin
      if (cp_q) begin
        // child goes into the slot above the top
        if (!ovf) begin
          we   = 1'b1;
          wa   = pix;
          wdat = child_q;
        end
      end else if (!leaf) begin
        we = 1'b1;
        if (two) begin
          if (top_q.ph == 2'd0) begin
            wdat = top_q; wdat.ph = 2'd1;
          end else begin
            wdat = mk(top_q.x + ax2, top_q.y + ay2, top_q.ax - ax2, top_q.ay - ay2,
                      top_q.bx, top_q.by);
          end
        end else begin
          priority case (top_q.ph)
            2'd0: begin wdat = top_q; wdat.ph = 2'd1; end
            2'd1: begin wdat = top_q; wdat.ph = 2'd2; end
            default: wdat = mk(top_q.x + (top_q.ax - dax) + (bx2 - dbx),
                               top_q.y + (top_q.ay - day) + (by2 - dby),
                               -bx2, -by2, -(top_q.ax - ax2), -(top_q.ay - ay2));
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      lvl_q    <= '0;
      lrem_q   <= '0;
      fin_q    <= 1'b1;
      ovalid_q <= 1'b0;
      cp_q     <= 1'b0;
      top_q    <= '0;
      child_q  <= '0;
      lx_q     <= '0;
      ly_q     <= '0;
      lsx_q    <= '0;
      lsy_q    <= '0;
      res_q    <= '0;
    end else begin
      if (emit) ovalid_q <= 1'b1;
      else if (pop_i && ovalid_q) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (rtake_o) begin
            if (req_i.restart) begin
              lrem_q <= '0;
              if (wd_s != '0 && ht_s != '0) begin
                fin_q <= 1'b0;
                lvl_q <= LW'(1);
                top_q <= (wd_s >= ht_s) ?
                  mk('0, '0, CW'(wd_s), '0, '0, CW'(ht_s)) :
                  mk('0, '0, '0, CW'(ht_s), CW'(wd_s), '0);
                st_q  <= S_STEP;
              end else begin
                fin_q    <= 1'b1;
                lvl_q    <= '0;
                res_q    <= '{pix_x: '0, pix_y: '0, final_pixel: 1'b0, walk_done: 1'b1};
              end
            end else if (fin_q) begin
              res_q    <= '{pix_x: '0, pix_y: '0, final_pixel: 1'b0, walk_done: 1'b1};
            end else begin
              st_q <= S_STEP;
            end
          end
        end
        S_READ: begin
          top_q <= stk_q[tix];
          st_q  <= S_STEP;
        end
        default: begin
          if (lrem_q != '0) begin
            lx_q     <= lx_q + lsx_q;
            ly_q     <= ly_q + lsy_q;
            lrem_q   <= lrem_q - CW'(1);
            res_q.pix_x <= lx_q[11:0];
            res_q.pix_y <= ly_q[11:0];
            res_q.walk_done <= 1'b0;
            res_q.final_pixel <= (lrem_q == CW'(1)) && (lvl_q == '0);
            if ((lrem_q == CW'(1)) && (lvl_q == '0)) fin_q <= 1'b1;
            st_q <= S_IDLE;
          end else if (lvl_q == '0) begin
            fin_q    <= 1'b1;
            res_q    <= '{pix_x: '0, pix_y: '0, final_pixel: 1'b0, walk_done: 1'b1};
            st_q     <= S_IDLE;
          end else if (cp_q) begin
            cp_q <= 1'b0;
            if (ovf) begin
              fin_q    <= 1'b1;
              lvl_q    <= '0;
              res_q    <= '{pix_x: '0, pix_y: '0, final_pixel: 1'b0, walk_done: 1'b1};
              st_q     <= S_IDLE;
            end else begin
              lvl_q <= lvl_q + LW'(1);
              top_q <= child_q;
            end
          end else if (leaf) begin
            lx_q <= top_q.x;
            ly_q <= top_q.y;
            if (h == 1) begin
              lrem_q <= $unsigned(w); lsx_q <= dax; lsy_q <= day;
            end else if (w == 1 && h > 1) begin
              lrem_q <= $unsigned(h); lsx_q <= dbx; lsy_q <= dby;
            end else begin
              lrem_q <= '0;
            end
            lvl_q <= lvl_q - LW'(1);
            if (lvl_q > LW'(1)) st_q <= S_READ;
          end else begin
            top_q <= wdat;
            if (two) begin
              if (top_q.ph == 2'd0) begin
                cp_q    <= 1'b1;
                child_q <= mk(top_q.x, top_q.y, ax2, ay2, top_q.bx, top_q.by);
              end
            end else if (top_q.ph == 2'd0) begin
              cp_q    <= 1'b1;
              child_q <= mk(top_q.x, top_q.y, bx2, by2, ax2, ay2);
            end else if (top_q.ph == 2'd1) begin
              cp_q    <= 1'b1;
              child_q <= mk(top_q.x + bx2, top_q.y + by2, top_q.ax, top_q.ay,
                            top_q.bx - bx2, top_q.by - by2);
            end
          end
        end
      endcase
    end
  end
endmodule

@@ hdl/gilbert_curve_address_generator_unit.sv @@
// Gilbert curve address generator.
// Each taken request yields one item: the next pixel of a running leaf or a
// walk_done item; on the way the walker may push and replace frames, pop
// leaves and reload a parent frame from the stack memory.
// One request is in flight at a time; the next is taken once idle and output free.
// Reset (rst_ni low, async): no walk, registers 1 x 1, queues empty; stack not cleared.
module gilbert_curve_address_generator_unit #(
  parameter int unsigned MAX_SIDE    = 4096,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        restart_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] pix_x_o,
  output logic [11:0] pix_y_o,
  output logic        final_pixel_o,
  output logic        walk_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  // Config registers, captured into the queue with each request.
  logic [12:0] wd_q, ht_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q <= 13'd1;
      ht_q <= 13'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gcag_pkg::REG_FRAME_WIDTH) wd_q <= cfg_data_i;
      else                                          ht_q <= cfg_data_i;
    end
  end

  logic           rvalid, rtake;
  gcag_pkg::req_t req;
  gcag_pkg::res_t res;

  gcag_front #(.DEPTH(2)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .restart_i,
    .wd_i(wd_q), .ht_i(ht_q), .rvalid_o(rvalid), .rtake_i(rtake), .req_o(req)
  );

  gcag_walk #(.MAX_SIDE(MAX_SIDE), .STACK_DEPTH(STACK_DEPTH)) u_walk (
    .clk_i, .rst_ni, .rvalid_i(rvalid), .rtake_o(rtake), .req_i(req),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign pix_x_o       = res.pix_x;
  assign pix_y_o       = res.pix_y;
  assign final_pixel_o = res.final_pixel;
  assign walk_done_o   = res.walk_done;
endmodule
